// ===== rtl/png_su_pkg.sv =====
// Shared constants, queue item type and predictor function for the scanline unfilter.
`default_nettype none

package png_su_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int BPP_MAX       = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_COLOR_MODE  = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] filter;
    logic       last;
    logic       first_row;
    logic       rgb;
    logic       bad;
  } item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [7:0]         pick;
    begin
      pa = $signed({3'b0, b}) - $signed({3'b0, c});
      pb = $signed({3'b0, a}) - $signed({3'b0, c});
      pc = pa + pb;
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) pick = a;
      else if (pb <= pc) pick = b;
      else pick = c;
      paeth = pick;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/png_su_fifo.sv =====
// Short register queue between the classifying front and the reconstruction back.
`default_nettype none

module png_su_fifo
  import png_su_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              head_valid,
  output logic [W-1:0]      head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == NW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/png_su_front.sv =====
// Front end: takes bytes, tracks row framing and filter codes, queues sample work.
`default_nettype none

module png_su_front
  import png_su_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW       = $clog2(MAX_WIDTH * BPP_MAX)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  input  wire logic [12:0] image_width,
  input  wire logic        color_mode,
  input  wire logic        queue_full,
  output logic             push,
  output item_t            push_item,
  output logic [CW-1:0]    push_col
);

  logic          halted;
  logic          halted_next;
  logic          await_filter;
  logic          await_filter_next;
  logic          first_row;
  logic          first_row_next;
  logic [2:0]    row_filter;
  logic [2:0]    row_filter_next;
  logic [CW-1:0] column;
  logic [CW-1:0] column_next;

  logic          accept;
  logic          eff_halt;
  logic          eff_await;
  logic          eff_first;
  logic [31:0]   width32;
  logic [31:0]   row_bytes;
  logic [31:0]   col_plus;
  logic          last;

  assign data_stall = queue_full;
  assign accept     = data_valid && !queue_full;
  assign push_col   = column;

  // a frame start restarts the row state before the byte is looked at
  assign eff_halt  = frame_start ? 1'b0 : halted;
  assign eff_await = frame_start ? 1'b1 : await_filter;
  assign eff_first = frame_start ? 1'b1 : first_row;

  always_comb begin
    width32 = {19'b0, image_width};
    if (width32 == 32'd0) begin
      width32 = 32'd1;
    end else if (width32 > 32'(MAX_WIDTH)) begin
      width32 = 32'(MAX_WIDTH);
    end
    row_bytes = color_mode ? (width32 + (width32 << 1)) : width32;
    col_plus  = 32'(column) + 32'd1;
    last      = (col_plus >= row_bytes);
  end

  always_comb begin
    halted_next       = halted;
    await_filter_next = await_filter;
    first_row_next    = first_row;
    row_filter_next   = row_filter;
    column_next       = column;
    push              = 1'b0;
    push_item         = '0;
    if (accept) begin
      halted_next       = eff_halt;
      await_filter_next = eff_await;
      first_row_next    = eff_first;
      if (frame_start) begin
        column_next = '0;
      end
      if (!eff_halt) begin
        if (eff_await) begin
          if (data_byte > {5'b0, FILT_PAETH}) begin
            halted_next   = 1'b1;
            push          = 1'b1;
            push_item.bad = 1'b1;
          end else begin
            row_filter_next   = data_byte[2:0];
            await_filter_next = 1'b0;
            column_next       = '0;
          end
        end else begin
          push                = 1'b1;
          push_item.data      = data_byte;
          push_item.filter    = row_filter;
          push_item.last      = last;
          push_item.first_row = first_row;
          push_item.rgb       = color_mode;
          if (last) begin
            await_filter_next = 1'b1;
            first_row_next    = 1'b0;
            column_next       = '0;
          end else begin
            column_next = col_plus[CW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted       <= 1'b0;
      await_filter <= 1'b1;
      first_row    <= 1'b1;
      row_filter   <= FILT_NONE;
      column       <= '0;
    end else begin
      halted       <= halted_next;
      await_filter <= await_filter_next;
      first_row    <= first_row_next;
      row_filter   <= row_filter_next;
      column       <= column_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/png_su_back.sv =====
// Back end: line store, neighbor registers, predictor and the output register.
`default_nettype none

module png_su_back
  import png_su_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int LINE_BYTES = MAX_WIDTH * BPP_MAX,
  localparam int CW         = $clog2(LINE_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire item_t         head_item,
  input  wire logic [CW-1:0] head_col,
  output logic               pop,
  output logic               pixel_valid,
  input  wire logic          pixel_stall,
  output logic [7:0]         pixel_byte,
  output logic               row_end,
  output logic               bad_filter
);

  logic [7:0]    line_mem [LINE_BYTES];
  logic [7:0]    rd_data;
  logic          fwd_hit;
  logic [7:0]    fwd_byte;

  logic          s_valid;
  item_t         s_item;
  logic [CW-1:0] s_col;
  logic          s_move;

  logic [23:0]   left_pixel;
  logic [23:0]   upper_left;

  logic          row_head;
  logic [7:0]    a;
  logic [7:0]    b;
  logic [7:0]    c;
  logic [8:0]    ab_sum;
  logic [7:0]    pred;
  logic [7:0]    x;

  assign s_move = s_valid && (!pixel_valid || !pixel_stall);
  assign pop    = head_valid && (!s_valid || s_move);

  always_comb begin
    row_head = (s_col == '0);
    if (row_head) begin
      a = 8'd0;
      c = 8'd0;
    end else begin
      a = s_item.rgb ? left_pixel[23:16] : left_pixel[7:0];
      c = s_item.rgb ? upper_left[23:16] : upper_left[7:0];
    end
    if (s_item.first_row) begin
      b = 8'd0;
    end else begin
      b = fwd_hit ? fwd_byte : rd_data;
    end
    ab_sum = {1'b0, a} + {1'b0, b};
    case (s_item.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    x = s_item.data + pred;
  end

  // line store: write the finished byte, read the next item's upper neighbor
  always_ff @(posedge clk) begin
    if (s_move && !s_item.bad) begin
      line_mem[s_col] <= x;
    end
    if (pop) begin
      rd_data <= line_mem[head_col];
    end
  end

  // bypass the byte that is written in the same cycle as it is read
  always_ff @(posedge clk) begin
    if (pop) begin
      fwd_hit  <= s_move && !s_item.bad && (head_col == s_col);
      fwd_byte <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s_item <= head_item;
      s_col  <= head_col;
    end
    if (s_move && !s_item.bad) begin
      left_pixel <= {(row_head ? 16'd0 : left_pixel[15:0]), x};
      upper_left <= {(row_head ? 16'd0 : upper_left[15:0]), b};
    end
    if (s_move) begin
      pixel_byte <= s_item.bad ? 8'd0 : x;
      row_end    <= s_item.bad ? 1'b0 : s_item.last;
      bad_filter <= s_item.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid     <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      s_valid     <= pop || (s_valid && !s_move);
      pixel_valid <= s_move || (pixel_valid && pixel_stall);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: register port, front, queue and back.
`default_nettype none

// Rebuilds 8-bit PNG samples from the inflated byte stream (filter byte, then
// image_width grey or RGB pixels per row) with the None, Sub, Up, Average and
// Paeth filters. Throughput is one byte per clock while data_stall is low:
// filter bytes and ignored bytes give no result, every sample gives one.
// A sample passes through the queue, the stage register and the output
// register. The clock rate is set by the back stage, where each byte's left
// neighbor feeds the Paeth predictor and adder of the next byte in the same
// cycle; the line store takes one write and one read per cycle. The line
// store needs no clearing after reset. A four-entry queue decouples input and
// output, so input keeps flowing while a result waits to be taken. A filter
// code above 4 gives one result with bad_filter set, and bytes are then
// dropped until the next frame_start.
module png_scanline_unfilter
  import png_su_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  output logic             pixel_valid,
  input  wire logic        pixel_stall,
  output logic [7:0]       pixel_byte,
  output logic             row_end,
  output logic             bad_filter
);

  localparam int CW = $clog2(MAX_WIDTH * BPP_MAX);
  localparam int QW = $bits(item_t) + CW;

  logic [12:0]   image_width;
  logic          color_mode;

  logic          queue_full;
  logic          push;
  item_t         push_item;
  logic [CW-1:0] push_col;
  logic          pop;
  logic          head_valid;
  logic [QW-1:0] head_data;
  item_t         head_item;
  logic [CW-1:0] head_col;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd1;
      color_mode  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: image_width <= pwdata[12:0];
        REG_COLOR_MODE:  color_mode  <= pwdata[0];
        default:         image_width <= image_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH: prdata = {19'b0, image_width};
      REG_COLOR_MODE:  prdata = {31'b0, color_mode};
      default:         prdata = '0;
    endcase
  end

  png_su_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .frame_start(frame_start),
    .image_width(image_width),
    .color_mode (color_mode),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item),
    .push_col   (push_col)
  );

  png_su_fifo #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_col, push_item}),
    .pop       (pop),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  assign head_item = head_data[$bits(item_t)-1:0];
  assign head_col  = head_data[QW-1:$bits(item_t)];

  png_su_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_col   (head_col),
    .pop        (pop),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_byte (pixel_byte),
    .row_end    (row_end),
    .bad_filter (bad_filter)
  );

endmodule

`default_nettype wire

// ===== rtl/png_su_checker.sv =====
// Port-level checks for the scanline unfilter, bound to the top level.
`default_nettype none

module png_su_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       data_stall,
  input wire logic       pixel_valid,
  input wire logic       pixel_stall,
  input wire logic [7:0] pixel_byte,
  input wire logic       row_end,
  input wire logic       bad_filter
);

  // an error result carries no sample and no row end
  a_bad_result_clean: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && bad_filter |-> pixel_byte == 8'd0 && !row_end)
    else $error("error result carries sample data");

  // reset drains the output register
  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("result shown right after reset");

  // reset empties the queue, so input is taken at once
  a_reset_no_stall: assert property (@(posedge clk)
    rst |=> !data_stall)
    else $error("input stalled right after reset");

  // hold a stalled result until its transfer
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=>
      pixel_valid && $stable(pixel_byte) && $stable(row_end) && $stable(bad_filter))
    else $error("stalled result changed");

endmodule

bind png_scanline_unfilter png_su_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .data_stall (data_stall),
  .pixel_valid(pixel_valid),
  .pixel_stall(pixel_stall),
  .pixel_byte (pixel_byte),
  .row_end    (row_end),
  .bad_filter (bad_filter)
);

`default_nettype wire
